// ===== src/bsct_pkg.sv =====
// shared types and constants of the sensorless commutation timer
`default_nettype none
package bsct_pkg;

    // event codes on the action field
    localparam logic [1:0] ACT_TIMER = 2'd0;
    localparam logic [1:0] ACT_ZC    = 2'd1;
    localparam logic [1:0] ACT_COMP  = 2'd2;
    localparam logic [1:0] ACT_START = 2'd3;

    // timer action codes on the result
    localparam logic [1:0] TA_NONE   = 2'd0;
    localparam logic [1:0] TA_LOAD   = 2'd1;
    localparam logic [1:0] TA_PRESET = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_FORWARD_DIR = 3'd0;
    localparam logic [2:0] CFG_BRAKE       = 3'd1;
    localparam logic [2:0] CFG_AUTO_ADV    = 3'd2;
    localparam logic [2:0] CFG_COARSE_ADV  = 3'd3;
    localparam logic [2:0] CFG_FINE_ADV    = 3'd4;
    localparam logic [2:0] CFG_BAD_LIMIT   = 3'd5;

    // fixed values
    localparam logic [15:0] INTERVAL_RESET = 16'd12500;
    localparam logic [15:0] START_INTERVAL = 16'd10000;
    localparam logic [13:0] CROSS_LIMIT    = 14'd10000;
    localparam logic [2:0]  STEP_LAST      = 3'd5;
    localparam logic [7:0]  CNT_MAX        = 8'd255;

    // configuration registers
    typedef struct packed {
        logic       forward_dir;
        logic       brake_active;
        logic       auto_advance_en;
        logic [2:0] coarse_advance;
        logic [5:0] fine_advance;
        logic [7:0] bad_limit;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic        is_timer;
        logic        is_zc;
        logic        is_comp;
        logic        is_start;
        logic [15:0] timer_count;
        logic        bemf;
    } t_item;

    // result without the wait time, held between the two back stages
    typedef struct packed {
        logic [2:0]  phase_step;
        logic        edge_rising;
        logic        drive_apply;
        logic [1:0]  timer_action;
        logic [15:0] interval_now;
        logic [7:0]  good_count;
        logic [13:0] crossings;
        logic        desync_flag;
        logic        wait_upd;
    } t_result;

endpackage
`default_nettype wire

// ===== src/bsct_front.sv =====
// front end: accepts requests and classifies them by event type
`default_nettype none
module bsct_front (
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [1:0]       i_action,
    input  wire logic [15:0]      i_timer_count,
    input  wire logic             i_comp_level,
    input  wire logic             i_full,
    output logic                  o_push,
    output bsct_pkg::t_item       o_item
);

    // hold off the sender while the queue is full
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // decode the event and form the back-emf state
    always_comb begin
        o_item             = '0;
        o_item.timer_count = i_timer_count;
        o_item.bemf        = ~i_comp_level;
        case (i_action)
            bsct_pkg::ACT_TIMER: o_item.is_timer = 1'b1;
            bsct_pkg::ACT_ZC:    o_item.is_zc    = 1'b1;
            bsct_pkg::ACT_COMP:  o_item.is_comp  = 1'b1;
            bsct_pkg::ACT_START: o_item.is_start = 1'b1;
            default:             o_item.is_timer = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/bsct_fifo.sv =====
// short request queue between front and back
`default_nettype none
module bsct_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bsct_pkg::t_item  i_item,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_nonempty,
    output bsct_pkg::t_item       o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    bsct_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full     = (r_count == CNT_FULL);
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/bsct_back.sv =====
// back end: commutation state update, then wait time and result register
`default_nettype none
module bsct_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bsct_pkg::t_cfg   i_cfg,
    input  wire logic             i_nonempty,
    input  wire bsct_pkg::t_item  i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [2:0]            o_phase_step,
    output logic                  o_edge_rising,
    output logic                  o_drive_apply,
    output logic [1:0]            o_timer_action,
    output logic [15:0]           o_wait_cycles,
    output logic [15:0]           o_interval_now,
    output logic [7:0]            o_good_count,
    output logic [13:0]           o_crossings,
    output logic                  o_desync_flag
);

    // motor state
    logic [2:0]  r_step;
    logic        r_rising, r_desync, r_running;
    logic [7:0]  r_good, r_bad;
    logic [15:0] r_prev_zc, r_this_zc, r_interval, r_wait;
    logic [13:0] r_cross;

    logic [2:0]  n_step;
    logic        n_rising, n_desync, n_running;
    logic [7:0]  n_good, n_bad;
    logic [15:0] n_prev_zc, n_this_zc, n_interval, n_wait;
    logic [13:0] n_cross;

    // pipeline registers
    bsct_pkg::t_result r_a;
    logic              r_a_valid;
    bsct_pkg::t_result r_out;
    logic [15:0]       r_out_wait;
    logic              r_out_valid;

    logic out_free, a_move, a_free;
    logic commute, good_sample;
    logic [2:0]  cm_step;
    logic        cm_rising, cm_desync;
    logic [16:0] zc_sum, avg_sum;
    logic [7:0]  bad_inc;
    logic [1:0]  taction;
    bsct_pkg::t_result n_a;

    // advance and wait
    logic [15:0] half, adv;
    logic [21:0] fine_prod;
    logic [15:0] coarse_prod;

    // stage handshakes
    assign out_free = !r_out_valid || !i_stall;
    assign a_move   = r_a_valid && out_free;
    assign a_free   = !r_a_valid || a_move;
    assign o_pop    = i_nonempty && a_free;

    // next step on a commutation
    always_comb begin
        cm_desync = r_desync;
        if (i_cfg.forward_dir) begin
            if (r_step >= bsct_pkg::STEP_LAST) begin
                cm_step   = '0;
                cm_desync = 1'b1;
            end else begin
                cm_step = r_step + 3'd1;
            end
            cm_rising = cm_step[0];
        end else begin
            if (r_step == '0 || r_step > bsct_pkg::STEP_LAST) begin
                cm_step   = bsct_pkg::STEP_LAST;
                cm_desync = 1'b1;
            end else begin
                cm_step = r_step - 3'd1;
            end
            cm_rising = ~cm_step[0];
        end
    end

    // state update for the request leaving the queue
    always_comb begin
        n_step     = r_step;
        n_rising   = r_rising;
        n_desync   = r_desync;
        n_running  = r_running;
        n_good     = r_good;
        n_bad      = r_bad;
        n_prev_zc  = r_prev_zc;
        n_this_zc  = r_this_zc;
        n_interval = r_interval;
        n_cross    = r_cross;
        taction    = bsct_pkg::TA_NONE;
        commute    = i_item.is_timer || (i_item.is_start && !r_running);
        zc_sum     = {1'b0, r_prev_zc} + {1'b0, r_this_zc};
        avg_sum    = {1'b0, r_interval} + {1'b0, zc_sum[16:1]};
        bad_inc    = (r_bad < bsct_pkg::CNT_MAX) ? r_bad + 8'd1 : r_bad;
        good_sample = r_rising ? i_item.bemf : !i_item.bemf;

        if (commute) begin
            n_step   = cm_step;
            n_rising = cm_rising;
            n_desync = cm_desync;
            n_good   = '0;
        end
        if (i_item.is_timer) begin
            n_interval = avg_sum[16:1];
            if (r_cross < bsct_pkg::CROSS_LIMIT) begin
                n_cross = r_cross + 14'd1;
            end
        end
        if (i_item.is_start && !r_running) begin
            n_interval = bsct_pkg::START_INTERVAL;
            n_running  = 1'b1;
            taction    = bsct_pkg::TA_PRESET;
        end
        if (i_item.is_zc) begin
            n_prev_zc = r_this_zc;
            n_this_zc = i_item.timer_count;
            n_bad     = '0;
            taction   = bsct_pkg::TA_LOAD;
        end
        if (i_item.is_comp) begin
            if (good_sample) begin
                if (r_good < bsct_pkg::CNT_MAX) begin
                    n_good = r_good + 8'd1;
                end
            end else begin
                n_bad = bad_inc;
                if (bad_inc > i_cfg.bad_limit) begin
                    n_good = '0;
                end
            end
        end

        n_a.phase_step   = n_step;
        n_a.edge_rising  = n_rising;
        n_a.drive_apply  = commute && !i_cfg.brake_active;
        n_a.timer_action = taction;
        n_a.interval_now = n_interval;
        n_a.good_count   = n_good;
        n_a.crossings    = n_cross;
        n_a.desync_flag  = n_desync;
        n_a.wait_upd     = i_item.is_timer;
    end

    // wait time from the registered interval
    always_comb begin
        half        = {1'b0, r_a.interval_now[15:1]};
        fine_prod   = {6'd0, r_a.interval_now} * {16'd0, i_cfg.fine_advance};
        coarse_prod = {3'd0, r_a.interval_now[15:3]} * {13'd0, i_cfg.coarse_advance};
        adv         = i_cfg.auto_advance_en ? fine_prod[21:6] : coarse_prod;
        if (r_a.wait_upd) begin
            n_wait = (adv > half) ? '0 : half - adv;
        end else begin
            n_wait = r_wait;
        end
    end

    // motor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_rising   <= 1'b0;
            r_desync   <= 1'b0;
            r_running  <= 1'b0;
            r_good     <= '0;
            r_bad      <= '0;
            r_prev_zc  <= '0;
            r_this_zc  <= '0;
            r_interval <= bsct_pkg::INTERVAL_RESET;
            r_cross    <= '0;
        end else if (o_pop) begin
            r_step     <= n_step;
            r_rising   <= n_rising;
            r_desync   <= n_desync;
            r_running  <= n_running;
            r_good     <= n_good;
            r_bad      <= n_bad;
            r_prev_zc  <= n_prev_zc;
            r_this_zc  <= n_this_zc;
            r_interval <= n_interval;
            r_cross    <= n_cross;
        end
    end

    // stage valids and held wait time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_wait      <= '0;
        end else begin
            if (a_free) begin
                r_a_valid <= o_pop;
            end
            if (out_free) begin
                r_out_valid <= r_a_valid;
            end
            if (a_move) begin
                r_wait <= n_wait;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a <= n_a;
        end
        if (a_move) begin
            r_out      <= r_a;
            r_out_wait <= n_wait;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_phase_step   = r_out.phase_step;
    assign o_edge_rising  = r_out.edge_rising;
    assign o_drive_apply  = r_out.drive_apply;
    assign o_timer_action = r_out.timer_action;
    assign o_wait_cycles  = r_out_wait;
    assign o_interval_now = r_out.interval_now;
    assign o_good_count   = r_out.good_count;
    assign o_crossings    = r_out.crossings;
    assign o_desync_flag  = r_out.desync_flag;

endmodule
`default_nettype wire

// ===== src/bldc_sensorless_commutation_timer.sv =====
// top level of the six-step sensorless commutation timer
`default_nettype none
// Six-step sensorless commutation sequencer. One request per clock is taken
// (timer elapsed, zero cross, comparator sample, start) and one result per
// request comes out in order, through the request queue, the state-update
// stage and the stage that works out the wait time and holds the result.
// A new request is taken every cycle while the queue has room; the queue
// (FIFO_DEPTH entries) absorbs requests while the output is stalled. The
// user must write the configuration registers through i_cfg_we, i_cfg_idx
// and i_cfg_data only while no request is in flight; the block does not
// enforce this. Indexes above five are ignored.
module bldc_sensorless_commutation_timer #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_timer_count,
    input  wire logic        i_comp_level,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_phase_step,
    output logic             o_edge_rising,
    output logic             o_drive_apply,
    output logic [1:0]       o_timer_action,
    output logic [15:0]      o_wait_cycles,
    output logic [15:0]      o_interval_now,
    output logic [7:0]       o_good_count,
    output logic [13:0]      o_crossings,
    output logic             o_desync_flag
);

    bsct_pkg::t_cfg  r_cfg;
    bsct_pkg::t_item front_item, queue_item;
    logic            push, pop, full, nonempty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_dir     <= 1'b1;
            r_cfg.brake_active    <= 1'b0;
            r_cfg.auto_advance_en <= 1'b0;
            r_cfg.coarse_advance  <= 3'd2;
            r_cfg.fine_advance    <= 6'd0;
            r_cfg.bad_limit       <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsct_pkg::CFG_FORWARD_DIR: r_cfg.forward_dir     <= i_cfg_data[0];
                bsct_pkg::CFG_BRAKE:       r_cfg.brake_active    <= i_cfg_data[0];
                bsct_pkg::CFG_AUTO_ADV:    r_cfg.auto_advance_en <= i_cfg_data[0];
                bsct_pkg::CFG_COARSE_ADV:  r_cfg.coarse_advance  <= i_cfg_data[2:0];
                bsct_pkg::CFG_FINE_ADV:    r_cfg.fine_advance    <= i_cfg_data[5:0];
                bsct_pkg::CFG_BAD_LIMIT:   r_cfg.bad_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request classification
    bsct_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_timer_count (i_timer_count),
        .i_comp_level  (i_comp_level),
        .i_full        (full),
        .o_push        (push),
        .o_item        (front_item)
    );

    // request queue
    bsct_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (front_item),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_item     (queue_item)
    );

    // commutation engine
    bsct_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_nonempty     (nonempty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_phase_step   (o_phase_step),
        .o_edge_rising  (o_edge_rising),
        .o_drive_apply  (o_drive_apply),
        .o_timer_action (o_timer_action),
        .o_wait_cycles  (o_wait_cycles),
        .o_interval_now (o_interval_now),
        .o_good_count   (o_good_count),
        .o_crossings    (o_crossings),
        .o_desync_flag  (o_desync_flag)
    );

    // step stays in the six-step range
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_phase_step <= bsct_pkg::STEP_LAST))
        else $error("phase step out of range");

    // crossing count saturates
    a_cross_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_crossings <= bsct_pkg::CROSS_LIMIT))
        else $error("crossing count above limit");

    // a zero-cross result never reports a commutation
    a_zc_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_apply) |-> (o_timer_action != bsct_pkg::TA_LOAD))
        else $error("drive applied on zero-cross result");

    // desync never clears once reported
    a_desync_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_desync_flag && !i_stall) ##1 o_valid |-> o_desync_flag)
        else $error("desync flag cleared");

endmodule
`default_nettype wire

// ===== sim/bldc_sensorless_commutation_timer_tb.sv =====
// self-checking testbench for the six-step sensorless commutation timer
module bldc_sensorless_commutation_timer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one commutation result as it leaves the block
    typedef struct packed {
        logic [2:0]  phase_step;
        logic        edge_rising;
        logic        drive_apply;
        logic [1:0]  timer_action;
        logic [15:0] wait_cycles;
        logic [15:0] interval_now;
        logic [7:0]  good_count;
        logic [13:0] crossings;
        logic        desync_flag;
    } t_commutation;

    // motor state predictor and queue of expected commutation results
    class commutation_scoreboard;
        // settings
        bit       fwd = 1'b1;
        bit       brake = 1'b0;
        bit       auto_adv = 1'b0;
        bit [2:0] coarse = 3'd2;
        bit [5:0] fine = 6'd0;
        bit [7:0] bad_lim = 8'd2;

        // motor state
        bit [2:0]  step = 3'd0;
        bit        rising = 1'b0;
        bit        desync = 1'b0;
        bit [7:0]  good = 8'd0;
        bit [7:0]  bad = 8'd0;
        bit [15:0] zc_prev = 16'd0;
        bit [15:0] zc_last = 16'd0;
        bit [15:0] interval = bsct_pkg::INTERVAL_RESET;
        bit [15:0] wait_time = 16'd0;
        bit [13:0] crosses = 14'd0;
        bit        running = 1'b0;

        t_commutation expected_q[$];
        int errors = 0;
        int checked = 0;
        int clamped = 0;
        int act_seen[4] = '{0, 0, 0, 0};

        function int pending();
            return expected_q.size();
        endfunction

        function void write_register(logic [2:0] idx, logic [7:0] data);
            case (idx)
                bsct_pkg::CFG_FORWARD_DIR: fwd = data[0];
                bsct_pkg::CFG_BRAKE:       brake = data[0];
                bsct_pkg::CFG_AUTO_ADV:    auto_adv = data[0];
                bsct_pkg::CFG_COARSE_ADV:  coarse = data[2:0];
                bsct_pkg::CFG_FINE_ADV:    fine = data[5:0];
                bsct_pkg::CFG_BAD_LIMIT:   bad_lim = data;
                default: ;
            endcase
        endfunction

        // one step around the six phases, wrapping marks desync
        function void commutate();
            if (fwd) begin
                if (step >= bsct_pkg::STEP_LAST) begin
                    step = 3'd0;
                    desync = 1'b1;
                end else begin
                    step++;
                end
                rising = step[0];
            end else begin
                if (step == 3'd0 || step > bsct_pkg::STEP_LAST) begin
                    step = bsct_pkg::STEP_LAST;
                    desync = 1'b1;
                end else begin
                    step--;
                end
                rising = ~step[0];
            end
            good = 8'd0;
        endfunction

        function void note_request(logic [1:0] action, logic [15:0] tcount, logic comp);
            t_commutation r;
            bit drive;
            bit bemf;
            bit ok;
            logic [1:0] ta;
            int unsigned avg;
            int unsigned adv;
            int unsigned half;
            drive = 1'b0;
            ta = bsct_pkg::TA_NONE;
            bemf = ~comp;
            act_seen[action]++;
            case (action)
                bsct_pkg::ACT_TIMER: begin
                    commutate();
                    drive = ~brake;
                    // average with the mean of the last two zero crosses
                    avg = (32'(zc_prev) + 32'(zc_last)) >> 1;
                    interval = 16'((32'(interval) + avg) >> 1);
                    if (!auto_adv) adv = 32'(interval >> 3) * 32'(coarse);
                    else adv = (32'(interval) * 32'(fine)) >> 6;
                    adv = adv & 32'hFFFF;
                    half = 32'(interval >> 1);
                    if (adv > half) begin
                        wait_time = 16'd0;
                        clamped++;
                    end else begin
                        wait_time = 16'(half - adv);
                    end
                    if (crosses < bsct_pkg::CROSS_LIMIT) crosses++;
                end
                bsct_pkg::ACT_ZC: begin
                    zc_prev = zc_last;
                    zc_last = tcount;
                    bad = 8'd0;
                    ta = bsct_pkg::TA_LOAD;
                end
                bsct_pkg::ACT_COMP: begin
                    ok = rising ? bemf : ~bemf;
                    if (ok) begin
                        if (good < bsct_pkg::CNT_MAX) good++;
                    end else begin
                        if (bad < bsct_pkg::CNT_MAX) bad++;
                        if (bad > bad_lim) good = 8'd0;
                    end
                end
                bsct_pkg::ACT_START: begin
                    if (!running) begin
                        commutate();
                        drive = ~brake;
                        interval = bsct_pkg::START_INTERVAL;
                        ta = bsct_pkg::TA_PRESET;
                        running = 1'b1;
                    end
                end
            endcase
            r.phase_step = step;
            r.edge_rising = rising;
            r.drive_apply = drive;
            r.timer_action = ta;
            r.wait_cycles = wait_time;
            r.interval_now = interval;
            r.good_count = good;
            r.crossings = crosses;
            r.desync_flag = desync;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%t mismatch: %s", $realtime, what);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d in result %0d",
                                          name, got, want, checked));
        endtask

        task check_result(t_commutation got);
            t_commutation want;
            if (expected_q.size() == 0) begin
                report_mismatch("result arrived with no request waiting");
                return;
            end
            want = expected_q.pop_front();
            compare_field("phase_step", got.phase_step, want.phase_step);
            compare_field("edge_rising", got.edge_rising, want.edge_rising);
            compare_field("drive_apply", got.drive_apply, want.drive_apply);
            compare_field("timer_action", got.timer_action, want.timer_action);
            compare_field("wait_cycles", got.wait_cycles, want.wait_cycles);
            compare_field("interval_now", got.interval_now, want.interval_now);
            compare_field("good_count", got.good_count, want.good_count);
            compare_field("crossings", got.crossings, want.crossings);
            compare_field("desync_flag", got.desync_flag, want.desync_flag);
            checked++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = 3'd0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = bsct_pkg::ACT_COMP;
    logic [15:0] i_timer_count = 16'd0;
    logic        i_comp_level = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_phase_step;
    logic        o_edge_rising;
    logic        o_drive_apply;
    logic [1:0]  o_timer_action;
    logic [15:0] o_wait_cycles;
    logic [15:0] o_interval_now;
    logic [7:0]  o_good_count;
    logic [13:0] o_crossings;
    logic        o_desync_flag;

    commutation_scoreboard sb = new();
    bit quiet_stretch = 1'b0;
    int sent_items = 0;

    bldc_sensorless_commutation_timer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_timer_count  (i_timer_count),
        .i_comp_level   (i_comp_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_phase_step   (o_phase_step),
        .o_edge_rising  (o_edge_rising),
        .o_drive_apply  (o_drive_apply),
        .o_timer_action (o_timer_action),
        .o_wait_cycles  (o_wait_cycles),
        .o_interval_now (o_interval_now),
        .o_good_count   (o_good_count),
        .o_crossings    (o_crossings),
        .o_desync_flag  (o_desync_flag)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // random output stall, off during the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= quiet_stretch ? 1'b0 : ($urandom_range(0, 99) < 9);
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_commutation got;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            got = {o_phase_step, o_edge_rising, o_drive_apply, o_timer_action,
                   o_wait_cycles, o_interval_now, o_good_count, o_crossings,
                   o_desync_flag};
            sb.check_result(got);
        end
    end

    // hand one request over and hold it until taken
    task automatic send_request(logic [1:0] action, logic [15:0] tcount, logic comp);
        i_valid <= 1'b1;
        i_action <= action;
        i_timer_count <= tcount;
        i_comp_level <= comp;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_request(action, tcount, comp);
        if (action != bsct_pkg::ACT_START) sent_items++;
        // random sender gap
        if (!quiet_stretch && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // sender pauses until every expected result is back
    task automatic wait_for_results();
        if (i_valid) i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // write all registers, plus the two unused indexes
    task automatic set_config(bit fwd, bit brake, bit auto_adv, bit [2:0] coarse,
                              bit [5:0] fine, bit [7:0] bad_lim);
        logic [7:0] vals [8];
        vals[bsct_pkg::CFG_FORWARD_DIR] = {7'($urandom), fwd};
        vals[bsct_pkg::CFG_BRAKE]       = {7'($urandom), brake};
        vals[bsct_pkg::CFG_AUTO_ADV]    = {7'($urandom), auto_adv};
        vals[bsct_pkg::CFG_COARSE_ADV]  = {5'($urandom), coarse};
        vals[bsct_pkg::CFG_FINE_ADV]    = {2'($urandom), fine};
        vals[bsct_pkg::CFG_BAD_LIMIT]   = bad_lim;
        vals[6] = 8'($urandom);
        vals[7] = 8'($urandom);
        for (int r = 0; r < 8; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            sb.write_register(3'(r), vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] random_count();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // comparator level that agrees with the expected back-emf edge
    function automatic logic good_level();
        return sb.rising ? 1'b0 : 1'b1;
    endfunction

    // zero cross, a few comparator samples, then the commutation
    task automatic send_revolution();
        int n;
        n = $urandom_range(0, 6);
        send_request(bsct_pkg::ACT_ZC, random_count(), 1'($urandom));
        repeat (n)
            send_request(bsct_pkg::ACT_COMP, 16'($urandom),
                         ($urandom_range(0, 99) < 80) ? good_level() : ~good_level());
        send_request(bsct_pkg::ACT_TIMER, 16'($urandom), 1'($urandom));
    endtask

    task automatic send_noise();
        int r;
        logic [1:0] a;
        r = $urandom_range(0, 99);
        if (r < 30) a = bsct_pkg::ACT_TIMER;
        else if (r < 55) a = bsct_pkg::ACT_ZC;
        else if (r < 92) a = bsct_pkg::ACT_COMP;
        else a = bsct_pkg::ACT_START;
        send_request(a, random_count(), 1'($urandom));
    endtask

    task automatic run_random_phase(int n);
        int stop;
        stop = sent_items + n;
        while (sent_items < stop) begin
            if ($urandom_range(0, 99) < 75) send_revolution();
            else send_noise();
            if ($urandom_range(0, 99) < 4) wait_for_results();
        end
        wait_for_results();
    endtask

    // main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: samples before start, zero cross extremes, start twice
        send_request(bsct_pkg::ACT_COMP, 16'd0, 1'b1);
        send_request(bsct_pkg::ACT_COMP, 16'd0, 1'b0);
        send_request(bsct_pkg::ACT_ZC, 16'h0000, 1'b0);
        send_request(bsct_pkg::ACT_ZC, 16'hFFFF, 1'b1);
        send_request(bsct_pkg::ACT_START, 16'h1234, 1'b0);
        send_request(bsct_pkg::ACT_START, 16'hFFFF, 1'b1);
        // good samples, then enough bad ones to pass the limit
        repeat (2) send_request(bsct_pkg::ACT_COMP, 16'd0, good_level());
        repeat (3) send_request(bsct_pkg::ACT_COMP, 16'd0, ~good_level());
        // full turn forward wraps the step
        repeat (6) send_request(bsct_pkg::ACT_TIMER, 16'hFFFF, 1'b1);
        // long zero-cross times push the interval up
        send_request(bsct_pkg::ACT_ZC, 16'hFFFF, 1'b0);
        send_request(bsct_pkg::ACT_ZC, 16'hFFFF, 1'b0);
        send_request(bsct_pkg::ACT_TIMER, 16'h0000, 1'b0);
        send_request(bsct_pkg::ACT_ZC, 16'h5555, 1'b1);
        send_request(bsct_pkg::ACT_COMP, 16'hAAAA, ~good_level());
        wait_for_results();

        // random phases through the corners of the settings
        set_config(1'b1, 1'b0, 1'b0, 3'd0, 6'd0, 8'd0);
        run_random_phase(25);
        set_config(1'b0, 1'b1, 1'b1, 3'd7, 6'd63, 8'd255);
        run_random_phase(25);
        set_config(1'b1, 1'b0, 1'b1, 3'd4, 6'd32, 8'd1);
        run_random_phase(25);
        set_config(1'b0, 1'b0, 1'b0, 3'd5, 6'd33, 8'd3);
        run_random_phase(25);
        repeat (2) begin
            set_config(1'($urandom), 1'($urandom), 1'($urandom), 3'($urandom),
                       6'($urandom), 8'($urandom));
            run_random_phase(25);
        end

        // good counter into saturation, no gaps and no stalls
        set_config(1'b1, 1'b0, 1'b0, 3'd2, 6'd0, 8'd255);
        quiet_stretch = 1'b1;
        repeat (258) send_request(bsct_pkg::ACT_COMP, 16'($urandom), good_level());
        quiet_stretch = 1'b0;
        repeat (4) send_request(bsct_pkg::ACT_COMP, 16'($urandom), ~good_level());
        send_request(bsct_pkg::ACT_ZC, random_count(), 1'b0);
        repeat (3) send_request(bsct_pkg::ACT_COMP, 16'd0, ~good_level());
        send_revolution();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

        $display("requests: %0d timer, %0d zero-cross, %0d comparator, %0d start",
                 sb.act_seen[bsct_pkg::ACT_TIMER], sb.act_seen[bsct_pkg::ACT_ZC],
                 sb.act_seen[bsct_pkg::ACT_COMP], sb.act_seen[bsct_pkg::ACT_START]);
        $display("%0d results checked, %0d waits clamped to zero, %0d mismatches",
                 sb.checked, sb.clamped, sb.errors);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results still expected", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/bsct_pkg.sv
src/bsct_front.sv
src/bsct_fifo.sv
src/bsct_back.sv
src/bldc_sensorless_commutation_timer.sv
sim/bldc_sensorless_commutation_timer_tb.sv
